@@ design/cc22_pkg.sv @@
package cc22_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int ACC_BITS    = 48;
  localparam int LEN_BITS    = 17;
  localparam int PROD_BITS   = 2 * SAMPLE_BITS + 1;
  localparam int NUM_VIS     = 8;
  localparam int NUM_BASE    = 4;
  localparam int LEN_RESET   = 1024;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [PROD_BITS-1:0]   prod_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;
  typedef logic        [LEN_BITS-1:0]    len_t;

  // visibility order: xx_re, xx_im, xy_re, xy_im, yx_re, yx_im, yy_re, yy_im
  typedef acc_t  [NUM_VIS-1:0] vis_t;
  typedef prod_t [NUM_VIS-1:0] prods_t;

  typedef enum logic [1:0] {
    SLOT_A0 = 2'd0,
    SLOT_A1 = 2'd1,
    SLOT_B0 = 2'd2,
    SLOT_B1 = 2'd3
  } slot_e;

  typedef struct packed {
    sample_t xr;
    sample_t xi;
    sample_t yr;
    sample_t yi;
  } station_t;

  // control from the pipeline to each baseline
  typedef struct packed {
    logic load;
    logic acc_en;
    logic acc_clr;
  } base_ctl_t;

  localparam acc_t ACC_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
  localparam acc_t ACC_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};

  // real part of a * conj(b)
  function automatic prod_t cmul_re(sample_t ar, sample_t ai, sample_t br, sample_t bi);
    logic signed [2*SAMPLE_BITS-1:0] p1;
    logic signed [2*SAMPLE_BITS-1:0] p2;
    p1 = ar * br;
    p2 = ai * bi;
    return PROD_BITS'(p1) + PROD_BITS'(p2);
  endfunction

  // imaginary part of a * conj(b)
  function automatic prod_t cmul_im(sample_t ar, sample_t ai, sample_t br, sample_t bi);
    logic signed [2*SAMPLE_BITS-1:0] p1;
    logic signed [2*SAMPLE_BITS-1:0] p2;
    p1 = ai * br;
    p2 = ar * bi;
    return PROD_BITS'(p1) - PROD_BITS'(p2);
  endfunction

  // exact sum, clamped to the accumulator range
  function automatic acc_t sat_acc(acc_t acc, prod_t p);
    logic signed [ACC_BITS:0] s;
    s = (ACC_BITS+1)'(acc) + (ACC_BITS+1)'(p);
    if (s[ACC_BITS] != s[ACC_BITS-1]) begin
      return s[ACC_BITS] ? ACC_MIN : ACC_MAX;
    end
    return s[ACC_BITS-1:0];
  endfunction

endpackage

@@ design/cc22_ifs.sv @@
interface cc22_in_if import cc22_pkg::*; ();
  logic    valid;
  logic    ready;
  logic [1:0] station_slot;
  sample_t x_real;
  sample_t x_imag;
  sample_t y_real;
  sample_t y_imag;

  modport source(output valid, station_slot, x_real, x_imag, y_real, y_imag, input ready);
  modport sink(input valid, station_slot, x_real, x_imag, y_real, y_imag, output ready);
endinterface

interface cc22_out_if import cc22_pkg::*; ();
  logic valid;
  logic ready;
  logic first_station;
  logic second_station;
  acc_t xx_re;
  acc_t xx_im;
  acc_t xy_re;
  acc_t xy_im;
  acc_t yx_re;
  acc_t yx_im;
  acc_t yy_re;
  acc_t yy_im;
  logic last_baseline;

  modport source(output valid, first_station, second_station, xx_re, xx_im, xy_re, xy_im,
                 yx_re, yx_im, yy_re, yy_im, last_baseline, input ready);
  modport sink(input valid, first_station, second_station, xx_re, xx_im, xy_re, xy_im,
               yx_re, yx_im, yy_re, yy_im, last_baseline, output ready);
endinterface

interface cc22_cfg_if import cc22_pkg::*; ();
  logic valid;
  logic ready;
  len_t integration_length;

  modport source(output valid, integration_length, input ready);
  modport sink(input valid, integration_length, output ready);
endinterface

@@ design/cc22_baseline.sv @@
module cc22_baseline import cc22_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  base_ctl_t ctl,
  input  station_t  a,
  input  station_t  b,
  output vis_t      acc_new
);

  prods_t prod;
  prods_t prod_next;
  vis_t   acc;

  always_comb begin
    prod_next[0] = cmul_re(a.xr, a.xi, b.xr, b.xi);
    prod_next[1] = cmul_im(a.xr, a.xi, b.xr, b.xi);
    prod_next[2] = cmul_re(a.xr, a.xi, b.yr, b.yi);
    prod_next[3] = cmul_im(a.xr, a.xi, b.yr, b.yi);
    prod_next[4] = cmul_re(a.yr, a.yi, b.xr, b.xi);
    prod_next[5] = cmul_im(a.yr, a.yi, b.xr, b.xi);
    prod_next[6] = cmul_re(a.yr, a.yi, b.yr, b.yi);
    prod_next[7] = cmul_im(a.yr, a.yi, b.yr, b.yi);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      prod <= prod_next;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_VIS; i++) begin
      acc_new[i] = sat_acc(acc[i], prod[i]);
    end
  end

  // emitting step hands acc_new to the output bank and restarts from zero
  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
    end else if (ctl.acc_en) begin
      acc <= ctl.acc_clr ? '0 : acc_new;
    end
  end

endmodule

@@ design/correlator_cell_2x2.sv @@
// 2x2 station block cross-correlator.
// samples: one station per transaction, station_slot 0..3 = A0, A1, B0, B1,
//   sent in slot order per time step. Slots 0..2 are held; slot 3 (B1) starts
//   a time step of sixteen complex multiply-accumulates into 48-bit
//   saturating accumulators.
// cfg: writes integration_length (0 acts as 1); write only while idle.
// vis: after integration_length time steps, four transactions in the order
//   A0B0, A1B0, A0B1, A1B1; last_baseline marks A1B1.
// Pipeline: a slot-3 transaction goes through the input register, the product
//   register, and the accumulators and output bank; the first result is valid
//   once the output bank has loaded.
// Throughput: one sample transaction per cycle when not stalled. The output
//   bank holds one finished integration; it is reloaded on the cycle its
//   last result leaves, so a length of 1 still streams one transaction per cycle.
// Stall: while the receiver holds off and the bank is full, a step that ends
//   an integration waits in the product register and samples.ready drops.
// Reset: held samples, accumulators and the step count clear to zero,
//   integration_length returns to 1024; the block is ready the cycle after.
module correlator_cell_2x2 import cc22_pkg::*; (
  input logic      clk,
  input logic      rst,
  cc22_in_if.sink  samples,
  cc22_cfg_if.sink cfg,
  cc22_out_if.source vis
);

  len_t      integration_length;
  len_t      steps_done;
  logic      a_valid;
  slot_e     a_slot;
  station_t  a_samp;
  station_t  held [3];
  logic      b_valid;
  logic      b_emit;
  logic      adv;
  logic      busy;
  logic [1:0] cnt;
  logic      last_beat;
  base_ctl_t ctl;
  vis_t      acc_new [NUM_BASE];
  vis_t      bank [NUM_BASE];
  vis_t      cur;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      integration_length <= len_t'(LEN_RESET);
    end else if (cfg.valid) begin
      integration_length <= cfg.integration_length;
    end
  end

  assign last_beat = vis.ready && cnt == 2'(NUM_BASE - 1);
  assign b_emit    = ({1'b0, steps_done} + (LEN_BITS+1)'(1))
                     >= {1'b0, integration_length};
  assign adv       = !(b_valid && b_emit) || !busy || last_beat;
  assign samples.ready = adv;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= samples.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && samples.valid) begin
      a_slot <= slot_e'(samples.station_slot);
      a_samp <= '{xr: samples.x_real, xi: samples.x_imag,
                  yr: samples.y_real, yi: samples.y_imag};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        held[i] <= '0;
      end
    end else if (adv && a_valid) begin
      case (a_slot)
        SLOT_A0: held[0] <= a_samp;
        SLOT_A1: held[1] <= a_samp;
        SLOT_B0: held[2] <= a_samp;
        default: ;
      endcase
    end
  end

  // product register stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid && a_slot == SLOT_B1;
    end
  end

  assign ctl.load    = adv && a_valid && a_slot == SLOT_B1;
  assign ctl.acc_en  = adv && b_valid;
  assign ctl.acc_clr = b_emit;

  for (genvar k = 0; k < NUM_BASE; k++) begin : g_base
    cc22_baseline u_base (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .a       (held[k % 2]),
      .b       ((k / 2 == 1) ? a_samp : held[2]),
      .acc_new (acc_new[k])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      steps_done <= '0;
    end else if (ctl.acc_en) begin
      steps_done <= b_emit ? '0 : steps_done + len_t'(1);
    end
  end

  // output bank
  always_ff @(posedge clk) begin
    if (ctl.acc_en && b_emit) begin
      bank <= acc_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.acc_en && b_emit) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (vis.valid && vis.ready) begin
      cnt <= cnt + 2'd1;
      if (last_beat) begin
        busy <= 1'b0;
      end
    end
  end

  assign cur                = bank[cnt];
  assign vis.valid          = busy;
  assign vis.first_station  = cnt[0];
  assign vis.second_station = cnt[1];
  assign vis.last_baseline  = cnt == 2'(NUM_BASE - 1);
  assign vis.xx_re          = cur[0];
  assign vis.xx_im          = cur[1];
  assign vis.xy_re          = cur[2];
  assign vis.xy_im          = cur[3];
  assign vis.yx_re          = cur[4];
  assign vis.yx_im          = cur[5];
  assign vis.yy_re          = cur[6];
  assign vis.yy_im          = cur[7];

  // an emitting step restarts the step count
  assert property (@(posedge clk) disable iff (rst)
    (ctl.acc_en && b_emit) |=> steps_done == '0)
    else $error("step count not cleared after emission");

  // results stay up until the fourth one is taken
  assert property (@(posedge clk) disable iff (rst)
    (vis.valid && !last_beat) |=> vis.valid)
    else $error("result transaction dropped early");

  // baselines leave in order
  assert property (@(posedge clk) disable iff (rst)
    (vis.valid && vis.ready && !last_beat) |=> cnt == 2'($past(cnt) + 2'd1))
    else $error("baseline order broken");

  // input stalls only behind a finished integration waiting for the bank
  assert property (@(posedge clk) disable iff (rst)
    !samples.ready |-> (b_valid && b_emit && busy))
    else $error("input stalled without cause");

endmodule
